[design/assert_macros.svh]
// Assertion helpers for the top module of the segment cut block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define MSC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define MSC_ASSERT(lbl, prop, msg) \
  `MSC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[design/msc_pkg.sv]
package msc_pkg;

  // Widths fixed by the interface fields.
  localparam int LEN_W = 10;
  localparam int CNT_W = 10;
  localparam int IDX_W = 2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_SEG_LEN_A = 2'd0;
  localparam logic [IDX_W-1:0] REG_SEG_LEN_B = 2'd1;
  localparam logic [IDX_W-1:0] REG_SEG_LEN_C = 2'd2;

  // One table entry: reachable flag and best segment count.
  typedef struct packed {
    logic             reach;
    logic [CNT_W-1:0] count;
  } entry_t;

  // One entry per segment length, as carried through a cell.
  typedef struct packed {
    entry_t a;
    entry_t b;
    entry_t c;
  } lanes_t;

  // The three configured segment lengths.
  typedef struct packed {
    logic [LEN_W-1:0] a;
    logic [LEN_W-1:0] b;
    logic [LEN_W-1:0] c;
  } lens_t;

endpackage

[design/msc_cell.sv]
module msc_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [msc_pkg::LEN_W-1:0]    tap_i,
  input  msc_pkg::lens_t               seg_len_i,
  input  msc_pkg::entry_t              new_i,
  input  msc_pkg::lanes_t              prev_i,
  output msc_pkg::lanes_t              cell_o
);

  msc_pkg::lanes_t cell_d, cell_q;

  // Each lane takes the new entry where its delay starts, else shifts on.
  always_comb begin
    cell_d   = prev_i;
    if (seg_len_i.a == tap_i) begin
      cell_d.a = new_i;
    end
    if (seg_len_i.b == tap_i) begin
      cell_d.b = new_i;
    end
    if (seg_len_i.c == tap_i) begin
      cell_d.c = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

[design/msc_pick.sv]
module msc_pick (
  input  msc_pkg::lanes_t              tap_i,
  input  msc_pkg::lens_t               seg_len_i,
  input  logic [msc_pkg::LEN_W-1:0]    step_i,
  output msc_pkg::entry_t              entry_o
);

  logic                      use_a, use_b, use_c;
  logic [msc_pkg::CNT_W-1:0] cand_a, cand_b, cand_c;

  // A lane counts only for a nonzero length that does not reach below zero.
  assign use_a = (seg_len_i.a != '0) && (seg_len_i.a <= step_i) && tap_i.a.reach;
  assign use_b = (seg_len_i.b != '0) && (seg_len_i.b <= step_i) && tap_i.b.reach;
  assign use_c = (seg_len_i.c != '0) && (seg_len_i.c <= step_i) && tap_i.c.reach;

  // Counts stay below the step index, so the increment cannot wrap.
  assign cand_a = tap_i.a.count + msc_pkg::CNT_W'(1);
  assign cand_b = tap_i.b.count + msc_pkg::CNT_W'(1);
  assign cand_c = tap_i.c.count + msc_pkg::CNT_W'(1);

  // Best of the usable candidates; length zero is reachable with no segments.
  always_comb begin
    entry_o = '0;
    if (step_i == '0) begin
      entry_o.reach = 1'b1;
    end else begin
      if (use_a) begin
        entry_o.reach = 1'b1;
        entry_o.count = cand_a;
      end
      if (use_b && (!entry_o.reach || cand_b > entry_o.count)) begin
        entry_o.reach = 1'b1;
        entry_o.count = cand_b;
      end
      if (use_c && (!entry_o.reach || cand_c > entry_o.count)) begin
        entry_o.reach = 1'b1;
        entry_o.count = cand_c;
      end
    end
  end

endmodule

[design/max_segment_cut_dp_unit.sv]
// Maximum segment cut: for a total length n, returns the largest number of
// segments of the three configured lengths that cover n exactly, or 0 when
// no exact cover exists. The best counts for lengths 0 to n are produced one
// per cycle, the last one waiting while the result slot is full; each new
// entry enters a chain of min(MAX_LEN, 1023) cells at three places set by
// the segment lengths, so that the entries at distances a, b and c come out
// of the chain's last cell just when they are needed. The last count of an
// item is registered as the result. A new item is taken once the previous
// one has left the chain, even while its result still waits to be read.
// Lengths above MAX_LEN return 0. No clearing is needed after reset.
// Segment lengths may be written only while the block is idle.
`include "assert_macros.svh"

module max_segment_cut_dp_unit #(
  parameter int MAX_LEN = 1023
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msc_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [msc_pkg::LEN_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [msc_pkg::LEN_W-1:0]     total_length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [msc_pkg::CNT_W-1:0]     max_segments_o
);

  // Only delays up to the largest usable length need cells.
  localparam int LEN_MAX = (1 << msc_pkg::LEN_W) - 1;
  localparam int NCELL   = (MAX_LEN < LEN_MAX) ? MAX_LEN : LEN_MAX;
  localparam logic [16:0] MAX_LEN_W = 17'(MAX_LEN);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FILL = 2'b10
  } state_e;

  state_e                      state_q, state_d;
  msc_pkg::lens_t              seg_len_q;
  logic [msc_pkg::LEN_W-1:0]   step_q, step_d;
  logic [msc_pkg::LEN_W-1:0]   n_q, n_d;
  logic                        over_q, over_d;
  logic                        out_valid_q, out_valid_d;
  logic [msc_pkg::CNT_W-1:0]   max_segments_q, max_segments_d;
  logic                        in_over;
  logic                        last, out_free, adv;
  msc_pkg::entry_t             entry;
  msc_pkg::lanes_t             chain [NCELL];
  msc_pkg::lanes_t             chain_in;

  // Configuration registers; writes beyond the last index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_len_q.a <= msc_pkg::LEN_W'(1);
      seg_len_q.b <= msc_pkg::LEN_W'(1);
      seg_len_q.c <= msc_pkg::LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msc_pkg::REG_SEG_LEN_A: seg_len_q.a <= cfg_data_i;
        msc_pkg::REG_SEG_LEN_B: seg_len_q.b <= cfg_data_i;
        msc_pkg::REG_SEG_LEN_C: seg_len_q.c <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The chain moves one step per filled entry and freezes while the last
  // entry waits for the output register.
  assign in_over  = {7'b0, total_length_i} > MAX_LEN_W;
  assign last     = (step_q == n_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign adv      = (state_q == S_FILL) && (!last || out_free);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    n_d            = n_q;
    over_d         = over_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    max_segments_d = max_segments_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_FILL;
          step_d  = '0;
          n_d     = in_over ? '0 : total_length_i;
          over_d  = in_over;
        end
      end
      S_FILL: begin
        if (adv) begin
          if (last) begin
            state_d        = S_IDLE;
            out_valid_d    = 1'b1;
            max_segments_d = (!over_q && entry.reach) ? entry.count : '0;
          end else begin
            step_d = step_q + msc_pkg::LEN_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      n_q         <= '0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      n_q         <= n_d;
      over_q      <= over_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_segments_q <= max_segments_d;
  end

  assign out_valid_o    = out_valid_q;
  assign max_segments_o = max_segments_q;

  // Entry for the current length from the three delayed entries.
  msc_pick u_pick (
    .tap_i     (chain[NCELL-1]),
    .seg_len_i (seg_len_q),
    .step_i    (step_q),
    .entry_o   (entry)
  );

  // Cell k delays an entry inserted there by NCELL - k steps.
  assign chain_in = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    msc_cell u_cell (
      .clk_i     (clk_i),
      .en_i      (adv),
      .tap_i     (msc_pkg::LEN_W'(NCELL - k)),
      .seg_len_i (seg_len_q),
      .new_i     (entry),
      .prev_i    ((k == 0) ? chain_in : chain[(k == 0) ? 0 : k-1]),
      .cell_o    (chain[k])
    );
  end

  `MSC_ASSERT(a_start_fill, (in_valid_i && in_ready_o) |=> (state_q == S_FILL && step_q == '0), "accepted beat did not start a fill at step zero")
  `MSC_ASSERT(a_step_bound, (state_q == S_FILL) |-> (step_q <= n_q), "fill step ran past the requested length")
  `MSC_ASSERT(a_result_src, $rose(out_valid_q) |-> $past(state_q == S_FILL), "result appeared without a finished fill")
  `MSC_ASSERT(a_hold_last, (state_q == S_FILL && last && !out_free) |=> (state_q == S_FILL && $stable(step_q)), "fill moved on while the result slot was full")

endmodule

[test/max_segment_cut_dp_unit_tb.sv]
module max_segment_cut_dp_unit_tb;

  // Index past the last segment length register; writes to it are dropped.
  localparam logic [msc_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned RX_LONG_HOLD = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES = 1100;
  localparam int unsigned NUM_PHASES = 7;
  localparam int unsigned BEATS_PER_PHASE = 18;

  // Tracks the segment length registers, predicts the best count for each
  // accepted length and compares the counts that come back in order.
  class seg_cut_scoreboard;
    logic [msc_pkg::LEN_W-1:0] seg_len [3];
    bit                        reach_tbl [TABLE_DEPTH];
    int unsigned               count_tbl [TABLE_DEPTH];
    logic [msc_pkg::CNT_W-1:0] expected_counts [$];
    int unsigned               failures;

    function new();
      seg_len = '{10'd1, 10'd1, 10'd1};
      failures = 0;
    endfunction

    function void write_seg_len(logic [msc_pkg::IDX_W-1:0] idx,
                                logic [msc_pkg::LEN_W-1:0] value);
      case (idx)
        msc_pkg::REG_SEG_LEN_A: seg_len[0] = value;
        msc_pkg::REG_SEG_LEN_B: seg_len[1] = value;
        msc_pkg::REG_SEG_LEN_C: seg_len[2] = value;
        default: ;
      endcase
    endfunction

    // Fills the table from length 1 up to total; each entry is one more than
    // the best reachable entry one segment length back.
    function logic [msc_pkg::CNT_W-1:0] best_cut_count(logic [msc_pkg::LEN_W-1:0] total);
      bit                        have;
      int unsigned               best;
      int unsigned               src;
      logic [msc_pkg::CNT_W-1:0] capped;
      reach_tbl[0] = 1'b1;
      count_tbl[0] = 0;
      for (int unsigned i = 1; i <= total; i++) begin
        have = 1'b0;
        best = 0;
        for (int s = 0; s < 3; s++) begin
          // A zero length never offers a candidate.
          if (seg_len[s] != 0 && seg_len[s] <= i) begin
            src = i - seg_len[s];
            if (reach_tbl[src] && (!have || count_tbl[src] + 1 > best)) begin
              best = count_tbl[src] + 1;
              have = 1'b1;
            end
          end
        end
        reach_tbl[i] = have;
        count_tbl[i] = best;
      end
      if (!reach_tbl[total])
        return '0;
      if (count_tbl[total] > 1023)
        capped = '1;
      else
        capped = msc_pkg::CNT_W'(count_tbl[total]);
      return capped;
    endfunction

    function void note_length(logic [msc_pkg::LEN_W-1:0] total);
      expected_counts.push_back(best_cut_count(total));
    endfunction

    function void check_count(logic [msc_pkg::CNT_W-1:0] actual);
      logic [msc_pkg::CNT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected max_segments beat, expected none, actual %0d",
                 $time, actual);
        failures++;
        return;
      end
      want = expected_counts.pop_front();
      if (actual !== want) begin
        $display("%0t: max_segments mismatch, expected %0d, actual %0d",
                 $time, want, actual);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_counts.size();
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [msc_pkg::IDX_W-1:0] cfg_idx_i;
  logic [msc_pkg::LEN_W-1:0] cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [msc_pkg::LEN_W-1:0] total_length_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [msc_pkg::CNT_W-1:0] max_segments_o;

  seg_cut_scoreboard sb;
  bit                quiet;
  bit                rx_hold_req;

  max_segment_cut_dp_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .total_length_i (total_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .max_segments_o (max_segments_o)
  );

  // Clock with a period of 8.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Lengths are mostly small to keep the run short; a few span the table.
  function automatic logic [msc_pkg::LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return msc_pkg::LEN_W'($urandom_range(0, 80));
    if (r < 95)
      return msc_pkg::LEN_W'($urandom_range(0, 1023));
    return 10'd1023;
  endfunction

  function automatic logic [msc_pkg::LEN_W-1:0] pick_seg_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return msc_pkg::LEN_W'($urandom_range(1, 8));
    if (r < 80)
      return msc_pkg::LEN_W'($urandom_range(1, 40));
    if (r < 90)
      return msc_pkg::LEN_W'($urandom_range(1, 1023));
    if (r < 95)
      return 10'd1023;
    return '0;
  endfunction

  // Register writes happen only while the block is idle.
  task automatic write_reg(logic [msc_pkg::IDX_W-1:0] idx,
                           logic [msc_pkg::LEN_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_seg_len(idx, value);
  endtask

  task automatic set_seg_lens(logic [msc_pkg::LEN_W-1:0] a,
                              logic [msc_pkg::LEN_W-1:0] b,
                              logic [msc_pkg::LEN_W-1:0] c);
    write_reg(msc_pkg::REG_SEG_LEN_A, a);
    write_reg(msc_pkg::REG_SEG_LEN_B, b);
    write_reg(msc_pkg::REG_SEG_LEN_C, c);
  endtask

  // Offers one length beat and holds it until the block takes it.
  task automatic send_length(logic [msc_pkg::LEN_W-1:0] total);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    total_length_i <= total;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_length(total);
  endtask

  // Stops offering and waits until every predicted count has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result side: check every count the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_count(max_segments_o);
  end

  // Receiver: alternating ready bursts and stalls, plus one long hold-off.
  initial begin
    int unsigned stall;
    int unsigned burst;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (rx_hold_req) begin
        repeat (RX_LONG_HOLD) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
        rx_hold_req = 1'b0;
      end else begin
        stall = pick_gap();
        repeat (stall) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
        burst = $urandom_range(1, 16);
        repeat (burst) begin
          @(negedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #8000000;
    $display("** max_segment_cut_dp_unit: FAILED **");
    $finish;
  end

  // Stimulus.
  initial begin
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    total_length_i = '0;
    rst_ni         = 1'b0;
    quiet          = 1'b0;
    rx_hold_req    = 1'b0;
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset lengths of one: the count equals the length, up to all ones.
    send_length(10'd0);
    send_length(10'd1);
    send_length(10'd5);
    send_length(10'd1023);
    drain_results();

    // A write past the last register must leave the lengths alone.
    write_reg(REG_UNUSED, 10'd1023);
    set_seg_lens(10'd3, 10'd5, 10'd7);
    send_length(10'd1);
    send_length(10'd2);
    send_length(10'd4);
    send_length(10'd11);
    send_length(10'd1023);
    drain_results();

    // Largest segment lengths: only zero and the full length are reachable.
    set_seg_lens(10'd1023, 10'd1023, 10'd1023);
    send_length(10'd1022);
    send_length(10'd1023);
    send_length(10'd0);
    drain_results();

    // Zero lengths never contribute; only even lengths are covered.
    set_seg_lens(10'd0, 10'd0, 10'd2);
    send_length(10'd1);
    send_length(10'd6);
    send_length(10'd1023);
    drain_results();

    set_seg_lens(10'd1023, 10'd0, 10'd1000);
    send_length(10'd1000);
    send_length(10'd1023);
    send_length(10'd23);
    drain_results();

    // Random phases, each under its own segment lengths.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, msc_pkg::LEN_W'($urandom_range(0, 1023)));
      set_seg_lens(pick_seg_len(), pick_seg_len(), pick_seg_len());
      quiet = (phase == 2);
      // Long receiver hold-off while lengths keep coming, to fill the block.
      if (phase == 3)
        rx_hold_req = 1'b1;
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        send_length(pick_length());
        // Sender pauses until every count is back.
        if (phase == 4 && k == BEATS_PER_PHASE / 2)
          drain_results();
      end
      drain_results();
    end

    quiet = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("** max_segment_cut_dp_unit: PASSED **");
    else
      $display("** max_segment_cut_dp_unit: FAILED **");
    $finish;
  end

endmodule
